FILE: src/wbrm_pkg.sv
// shared types and constants for the windowed byte rate meter
package wbrm_pkg;

    localparam int OP_W     = 2;
    localparam int TIME_W   = 32;
    localparam int AMOUNT_W = 24;
    localparam int RATE_W   = 48;
    localparam int TOTAL_W  = 64;

    localparam logic [OP_W-1:0] OP_COUNT   = 2'd0;
    localparam logic [OP_W-1:0] OP_START   = 2'd1;
    localparam logic [OP_W-1:0] OP_STOP    = 2'd2;
    localparam logic [OP_W-1:0] OP_MEASURE = 2'd3;

    localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_COUNT,
        ST_SUM,
        ST_DIV,
        ST_FIN
    } wbrm_state_t;

    typedef struct packed {
        logic load;
        logic scan_clr;
        logic cnt_run;
        logic sum_run;
        logic div_start;
        logic div_run;
        logic out_load;
    } wbrm_cmd_t;

    typedef struct packed {
        logic is_count;
        logic running;
        logic scan_done;
        logic div_done;
        logic out_free;
    } wbrm_sts_t;

endpackage

FILE: src/wbrm_ctrl.sv
// sequencer: accept, slot update scan, window sum scan, divide, result hand-off
module wbrm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wbrm_pkg::wbrm_sts_t sts,
    output wbrm_pkg::wbrm_cmd_t cmd
);
    import wbrm_pkg::*;

    wbrm_state_t state_reg;
    wbrm_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                priority if (sts.is_count) begin
                    state_next = ST_COUNT;
                end else if (sts.running) begin
                    state_next = ST_SUM;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_COUNT: begin
                cmd.cnt_run = 1'b1;
                if (sts.scan_done) begin
                    cmd.scan_clr = 1'b1;
                    state_next   = sts.running ? ST_SUM : ST_FIN;
                end
            end
            ST_SUM: begin
                cmd.sum_run = 1'b1;
                if (sts.scan_done) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV: begin
                cmd.div_run = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/wbrm_dpath.sv
// timer, totals, sample slot memory with scan engine, divider and result register
module wbrm_dpath #(
    parameter int SLOTS      = 20,
    parameter int WINDOW_SEC = 20
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  wbrm_pkg::wbrm_cmd_t             cmd,
    output wbrm_pkg::wbrm_sts_t             sts,
    input  logic [wbrm_pkg::OP_W-1:0]       s_op,
    input  logic [wbrm_pkg::TIME_W-1:0]     s_now_sec,
    input  logic [wbrm_pkg::AMOUNT_W-1:0]   s_byte_amount,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [wbrm_pkg::RATE_W-1:0]     m_rate,
    output logic                            m_running,
    output logic [wbrm_pkg::TOTAL_W-1:0]    m_total_bytes,
    output logic [wbrm_pkg::TIME_W-1:0]     m_total_seconds
);
    import wbrm_pkg::*;

    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SPAN_W = $clog2(WINDOW_SEC + 1);
    localparam int SUM_W  = RATE_W + $clog2(SLOTS);
    localparam int DIV_W  = $clog2(SUM_W);
    localparam int SLOT_W = TIME_W + RATE_W;

    // transaction registers and timer state
    logic [OP_W-1:0]     op_reg;
    logic [TIME_W-1:0]   now_reg;
    logic [AMOUNT_W-1:0] amount_reg;
    logic [TIME_W-1:0]   start_reg;
    logic [TIME_W-1:0]   used_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [CNT_W-1:0]    filled_reg;

    // slot memory
    logic [SLOT_W-1:0]   slot_mem [SLOTS];
    logic [SLOTS-1:0]    valid_reg;
    logic [SLOT_W-1:0]   rd_data_reg;
    logic                rd_valid_reg;

    // scan engine
    logic [CNT_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic                pend_reg;
    logic [SUM_W-1:0]    sum_reg;

    // divider
    logic [SUM_W-1:0]    quo_reg;
    logic [SPAN_W-1:0]   rem_reg;
    logic [DIV_W-1:0]    div_cnt_reg;

    // result register
    logic                m_valid_reg;
    logic [RATE_W-1:0]   m_rate_reg;
    logic                m_running_reg;
    logic [TOTAL_W-1:0]  m_total_bytes_reg;
    logic [TIME_W-1:0]   m_total_seconds_reg;

    logic                running;
    logic [TIME_W-1:0]   elapsed;
    logic [SPAN_W-1:0]   span;
    logic [TIME_W-1:0]   slot_stamp;
    logic [RATE_W-1:0]   slot_bytes;
    logic [TIME_W-1:0]   age;
    logic                age_neg;
    logic                stamp_eq;
    logic                stamp_old;
    logic                hit;
    logic                issue_ok;
    logic                issue;
    logic                wr_en;
    logic [RATE_W:0]     acc_sum;
    logic [RATE_W-1:0]   acc_sat;
    logic                in_window;
    logic [SPAN_W:0]     trial;
    logic                trial_ge;
    logic [RATE_W-1:0]   rate_sat;

    assign running = (start_reg != '0);

    // elapsed time clamped to one window, at least one second
    assign elapsed = now_reg - start_reg;
    always_comb begin
        priority if (elapsed[TIME_W-1] || elapsed == '0) begin
            span = SPAN_W'(1);
        end else if (elapsed < TIME_W'(WINDOW_SEC)) begin
            span = elapsed[SPAN_W-1:0];
        end else begin
            span = SPAN_W'(WINDOW_SEC);
        end
    end

    // never-written slots read as zero
    assign slot_stamp = rd_valid_reg ? rd_data_reg[SLOT_W-1:RATE_W] : '0;
    assign slot_bytes = rd_valid_reg ? rd_data_reg[RATE_W-1:0] : '0;
    assign age        = now_reg - slot_stamp;
    assign age_neg    = age[TIME_W-1];
    assign stamp_eq   = (slot_stamp == now_reg);
    assign stamp_old  = !age_neg && (age > TIME_W'(WINDOW_SEC));
    assign hit        = cmd.cnt_run && pend_reg && (stamp_eq || stamp_old);
    assign in_window  = age_neg || (age <= TIME_W'(span));

    assign acc_sum = {1'b0, slot_bytes} + (RATE_W + 1)'(amount_reg);
    assign acc_sat = acc_sum[RATE_W] ? RATE_MAX : acc_sum[RATE_W-1:0];

    always_comb begin
        if (cmd.cnt_run) begin
            issue_ok = (idx_reg <= filled_reg) && (idx_reg < CNT_W'(SLOTS));
        end else begin
            issue_ok = (idx_reg < filled_reg);
        end
    end

    assign issue = (cmd.cnt_run || cmd.sum_run) && issue_ok && !hit;
    assign wr_en = hit;

    assign sts.is_count  = (op_reg == OP_COUNT);
    assign sts.running   = running;
    assign sts.scan_done = hit || ((cmd.cnt_run || cmd.sum_run) && !pend_reg && !issue_ok);
    assign sts.div_done  = cmd.div_run && (div_cnt_reg == DIV_W'(SUM_W - 1));
    assign sts.out_free  = !m_valid_reg || m_ready;

    // transaction capture, timer and totals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= '0;
            used_reg  <= '0;
            total_reg <= '0;
        end else if (cmd.load) begin
            unique case (s_op)
                OP_COUNT: begin
                    total_reg <= total_reg + TOTAL_W'(s_byte_amount);
                end
                OP_START: begin
                    if (start_reg == '0) begin
                        start_reg <= s_now_sec;
                    end
                end
                OP_STOP: begin
                    if (start_reg != '0) begin
                        used_reg  <= used_reg + (s_now_sec - start_reg);
                        start_reg <= '0;
                    end
                end
                OP_MEASURE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg     <= s_op;
            now_reg    <= s_now_sec;
            amount_reg <= s_byte_amount;
        end
    end

    // slot memory: one read and one write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            if (stamp_eq) begin
                slot_mem[pend_idx_reg] <= {now_reg, acc_sat};
            end else begin
                slot_mem[pend_idx_reg] <= {now_reg, RATE_W'(amount_reg)};
            end
        end
        if (issue) begin
            rd_data_reg <= slot_mem[idx_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            filled_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[pend_idx_reg] <= 1'b1;
                if (!stamp_eq && filled_reg < CNT_W'(SLOTS)) begin
                    filled_reg <= filled_reg + CNT_W'(1);
                end
            end
            if (issue) begin
                rd_valid_reg <= valid_reg[idx_reg[IDX_W-1:0]];
            end
        end
    end

    // scan engine: read one slot per cycle, evaluate the previous read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end else if (cmd.load || cmd.scan_clr) begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= issue;
            if (issue) begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            pend_idx_reg <= idx_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load || cmd.scan_clr) begin
            sum_reg <= '0;
        end else if (cmd.sum_run && pend_reg && in_window) begin
            sum_reg <= sum_reg + SUM_W'(slot_bytes);
        end
    end

    // restoring divider, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[SUM_W-1]};
    assign trial_ge = (trial >= (SPAN_W + 1)'(span));

    always_ff @(posedge aclk) begin
        if (cmd.div_start) begin
            quo_reg     <= sum_reg;
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end else if (cmd.div_run) begin
            quo_reg     <= {quo_reg[SUM_W-2:0], trial_ge};
            rem_reg     <= trial_ge ? SPAN_W'(trial - (SPAN_W + 1)'(span))
                                    : trial[SPAN_W-1:0];
            div_cnt_reg <= div_cnt_reg + DIV_W'(1);
        end
    end

    assign rate_sat = (quo_reg > SUM_W'(RATE_MAX)) ? RATE_MAX : quo_reg[RATE_W-1:0];

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_rate_reg          <= running ? rate_sat : '0;
            m_running_reg       <= running;
            m_total_bytes_reg   <= total_reg;
            m_total_seconds_reg <= used_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_rate          = m_rate_reg;
    assign m_running       = m_running_reg;
    assign m_total_bytes   = m_total_bytes_reg;
    assign m_total_seconds = m_total_seconds_reg;

endmodule

FILE: src/windowed_byte_rate_meter.sv
// top level of the windowed byte rate meter
//
// input channel (s_valid/s_ready): one transaction per event carrying an op
// (count bytes, start timer, stop timer, measure), the time in seconds and a
// byte count. output channel (m_valid/m_ready): one transaction per input with
// the recent rate in bytes per second, the running flag and both totals.
// one event is handled at a time. a count event walks the sample slots through
// the slot memory, one slot per cycle; while the timer runs, every event, after
// any count walk, gets a walk that sums the recent slots, and a restoring
// divider produces one quotient bit per cycle. s_ready returns the cycle after
// the result is loaded.
// the result sits in an output register, so the next event is taken while the
// receiver stalls; a second result waits until the first is taken.
// reset clears the timer, the totals, the fill count and the slot valid bits,
// and the block is ready right after reset.
module windowed_byte_rate_meter #(
    parameter int SLOTS      = 20,
    parameter int WINDOW_SEC = 20
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [wbrm_pkg::OP_W-1:0]       s_op,
    input  logic [wbrm_pkg::TIME_W-1:0]     s_now_sec,
    input  logic [wbrm_pkg::AMOUNT_W-1:0]   s_byte_amount,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [wbrm_pkg::RATE_W-1:0]     m_rate,
    output logic                            m_running,
    output logic [wbrm_pkg::TOTAL_W-1:0]    m_total_bytes,
    output logic [wbrm_pkg::TIME_W-1:0]     m_total_seconds
);
    import wbrm_pkg::*;

    wbrm_cmd_t cmd;
    wbrm_sts_t sts;

    wbrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    wbrm_dpath #(
        .SLOTS      (SLOTS),
        .WINDOW_SEC (WINDOW_SEC)
    ) u_dpath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_op            (s_op),
        .s_now_sec       (s_now_sec),
        .s_byte_amount   (s_byte_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rate          (m_rate),
        .m_running       (m_running),
        .m_total_bytes   (m_total_bytes),
        .m_total_seconds (m_total_seconds)
    );

endmodule

FILE: tb/tb_windowed_byte_rate_meter.sv
// testbench for the windowed byte rate meter: random and directed events checked against a shadow model
module tb_windowed_byte_rate_meter;
    timeunit 1ns;
    timeprecision 1ps;

    import wbrm_pkg::*;

    localparam int SLOT_COUNT  = 20;
    localparam int WINDOW_SECS = 20;
    localparam int EVENT_GOAL  = 1050;

    typedef struct {
        logic [RATE_W-1:0]  rate;
        logic               running;
        logic [TOTAL_W-1:0] total_bytes;
        logic [TIME_W-1:0]  total_seconds;
    } meter_report_t;

    // mirror of the meter state plus the reports it owes
    class meter_shadow;
        logic [TIME_W-1:0]  timer_origin;
        logic [TIME_W-1:0]  timer_accum;
        logic [TOTAL_W-1:0] grand_total;
        logic [TIME_W-1:0]  stamp_at [SLOT_COUNT];
        logic [RATE_W-1:0]  bytes_at [SLOT_COUNT];
        int                 live_slots;
        meter_report_t      owed_reports [$];
        int                 mismatches;

        function new();
            timer_origin = '0;
            timer_accum  = '0;
            grand_total  = '0;
            live_slots   = 0;
            mismatches   = 0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                stamp_at[i] = '0;
                bytes_at[i] = '0;
            end
        endfunction

        function void add_bytes(logic [TIME_W-1:0] now, logic [AMOUNT_W-1:0] amount);
            logic [TIME_W-1:0] age;
            logic [RATE_W:0]   acc;
            bit                hit;
            hit = 1'b0;
            grand_total += TOTAL_W'(amount);
            for (int i = 0; i <= live_slots && i < SLOT_COUNT && !hit; i++) begin
                age = now - stamp_at[i];
                if (stamp_at[i] == now) begin
                    acc = {1'b0, bytes_at[i]} + (RATE_W + 1)'(amount);
                    bytes_at[i] = acc[RATE_W] ? RATE_MAX : acc[RATE_W-1:0];
                    hit = 1'b1;
                end else if (!age[TIME_W-1] && age > WINDOW_SECS) begin
                    stamp_at[i] = now;
                    bytes_at[i] = RATE_W'(amount);
                    if (live_slots < SLOT_COUNT)
                        live_slots++;
                    hit = 1'b1;
                end
            end
        endfunction

        function logic [RATE_W-1:0] window_rate(logic [TIME_W-1:0] now);
            logic [TIME_W-1:0]  elapsed;
            logic [TIME_W-1:0]  span;
            logic [TIME_W-1:0]  age;
            logic [TOTAL_W-1:0] sum;
            logic [TOTAL_W-1:0] quot;
            if (timer_origin == '0)
                return '0;
            elapsed = now - timer_origin;
            if (elapsed[TIME_W-1])
                span = 1;
            else if (elapsed < WINDOW_SECS)
                span = elapsed;
            else
                span = WINDOW_SECS;
            if (span == 0)
                span = 1;
            sum = '0;
            // stamps ahead of now count as recent
            for (int i = 0; i < live_slots; i++) begin
                age = now - stamp_at[i];
                if (age[TIME_W-1] || age <= span)
                    sum += TOTAL_W'(bytes_at[i]);
            end
            quot = sum / TOTAL_W'(span);
            return (quot > TOTAL_W'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
        endfunction

        function void note_event(logic [OP_W-1:0] op, logic [TIME_W-1:0] now,
                                 logic [AMOUNT_W-1:0] amount);
            meter_report_t r;
            case (op)
                OP_COUNT: add_bytes(now, amount);
                OP_START: if (timer_origin == '0) timer_origin = now;
                OP_STOP: begin
                    if (timer_origin != '0) begin
                        timer_accum += now - timer_origin;
                        timer_origin = '0;
                    end
                end
                OP_MEASURE: ;
                default: ;
            endcase
            r.rate          = window_rate(now);
            r.running       = (timer_origin != '0);
            r.total_bytes   = grand_total;
            r.total_seconds = timer_accum;
            owed_reports.push_back(r);
        endfunction

        function void compare_field(string field, logic [TOTAL_W-1:0] want,
                                    logic [TOTAL_W-1:0] got);
            if (got !== want) begin
                $display("%0t ns: %s mismatch, expected %0d actual %0d",
                         $time, field, want, got);
                mismatches++;
            end
        endfunction

        function void check_report(logic [RATE_W-1:0] rate, logic running,
                                   logic [TOTAL_W-1:0] total_bytes,
                                   logic [TIME_W-1:0] total_seconds);
            meter_report_t want;
            if (owed_reports.size() == 0) begin
                $display("%0t ns: unexpected report, expected none actual rate %0d bytes %0d",
                         $time, rate, total_bytes);
                mismatches++;
                return;
            end
            want = owed_reports.pop_front();
            compare_field("rate", TOTAL_W'(want.rate), TOTAL_W'(rate));
            compare_field("running", TOTAL_W'(want.running), TOTAL_W'(running));
            compare_field("total_bytes", want.total_bytes, total_bytes);
            compare_field("total_seconds", TOTAL_W'(want.total_seconds), TOTAL_W'(total_seconds));
        endfunction

        function int owed();
            return owed_reports.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn         = 1'b0;
    logic                s_valid         = 1'b0;
    logic                s_ready;
    logic [OP_W-1:0]     s_op            = OP_MEASURE;
    logic [TIME_W-1:0]   s_now_sec       = '0;
    logic [AMOUNT_W-1:0] s_byte_amount   = '0;
    logic                m_valid;
    logic                m_ready         = 1'b0;
    logic [RATE_W-1:0]   m_rate;
    logic                m_running;
    logic [TOTAL_W-1:0]  m_total_bytes;
    logic [TIME_W-1:0]   m_total_seconds;

    meter_shadow       shadow;
    int unsigned       burst_left  = 0;
    int unsigned       events_sent = 0;
    int unsigned       rx_cycle    = 0;
    int unsigned       rx_hold     = 0;
    logic [TIME_W-1:0] cur_time    = 100;

    windowed_byte_rate_meter #(
        .SLOTS      (SLOT_COUNT),
        .WINDOW_SEC (WINDOW_SECS)
    ) i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_now_sec       (s_now_sec),
        .s_byte_amount   (s_byte_amount),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rate          (m_rate),
        .m_running       (m_running),
        .m_total_bytes   (m_total_bytes),
        .m_total_seconds (m_total_seconds)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb_windowed_byte_rate_meter failed");
        $finish;
    end

    // receiver: steady, choppy and long-stall phases in turn
    always @(posedge aclk) begin
        rx_cycle++;
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            case ((rx_cycle / 400) % 3)
                0: ;
                1: if ($urandom_range(0, 3) == 0) rx_hold = $urandom_range(1, 3);
                default: if ($urandom_range(0, 40) == 0) rx_hold = $urandom_range(5, 40);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            shadow.check_report(m_rate, m_running, m_total_bytes, m_total_seconds);
    end

    task automatic offer_event(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                               input logic [AMOUNT_W-1:0] amount);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            // every fourth stretch of events goes back to back
            if ((events_sent / 200) % 4 == 3)
                gap = 0;
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_op          <= op;
        s_now_sec     <= now;
        s_byte_amount <= amount;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        shadow.note_event(op, now, amount);
        events_sent++;
    endtask

    function automatic logic [AMOUNT_W-1:0] pick_amount();
        case ($urandom_range(0, 19))
            0:         return '0;
            1:         return {AMOUNT_W{1'b1}};
            2, 3, 4:   return AMOUNT_W'($urandom);
            default:   return AMOUNT_W'($urandom_range(1, 3000));
        endcase
    endfunction

    // start, a run of counts, measures and the odd start with time creeping forward, then mostly a stop
    task automatic run_session();
        int unsigned       steps;
        int unsigned       roll;
        logic [TIME_W-1:0] t;
        logic [OP_W-1:0]   op;
        steps = $urandom_range(8, 40);
        case ($urandom_range(0, 15))
            0:       cur_time = $urandom;
            1:       cur_time = 32'hFFFF_FFF0 + $urandom_range(0, 12);
            default: cur_time += $urandom_range(0, 30);
        endcase
        if (cur_time == '0)
            cur_time = 1;
        offer_event(OP_START, cur_time, pick_amount());
        repeat (steps) begin
            cur_time += $urandom_range(0, 2);
            t = cur_time;
            if ($urandom_range(0, 9) == 0)
                t = cur_time - $urandom_range(1, 25);
            else if ($urandom_range(0, 19) == 0)
                t = cur_time + $urandom_range(1, 5);
            roll = $urandom_range(0, 19);
            op = (roll < 15) ? OP_COUNT : (roll < 19) ? OP_MEASURE : OP_START;
            offer_event(op, t, pick_amount());
        end
        if ($urandom_range(0, 4) != 0)
            offer_event(OP_STOP, cur_time + $urandom_range(0, 3), pick_amount());
    endtask

    task automatic run_noise(input int unsigned count);
        logic [TIME_W-1:0] t;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0:       t = $urandom;
                1:       t = $urandom_range(0, 3);
                default: t = cur_time + $urandom_range(0, 40) - 20;
            endcase
            offer_event(OP_W'($urandom_range(0, 3)), t, pick_amount());
        end
    endtask

    initial begin
        shadow = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, timer corners, wraparound times
        offer_event(OP_MEASURE, 32'd0, 24'd0);
        offer_event(OP_COUNT, 32'd0, 24'd100);       // matches an unfilled slot stamp
        offer_event(OP_COUNT, 32'd5, 24'd7);         // nothing fits, bytes dropped from table
        offer_event(OP_START, 32'd0, 24'd0);         // start at zero keeps the timer stopped
        offer_event(OP_STOP, 32'd3, 24'd0);          // stop while stopped
        offer_event(OP_COUNT, 32'd30, 24'hFF_FFFF);
        offer_event(OP_COUNT, 32'd30, 24'd1);
        offer_event(OP_START, 32'd31, 24'd0);
        offer_event(OP_MEASURE, 32'd31, 24'd0);      // zero elapsed clamps up
        offer_event(OP_COUNT, 32'd32, 24'd500);
        offer_event(OP_START, 32'd33, 24'd0);        // start while running
        offer_event(OP_MEASURE, 32'd45, 24'd0);
        offer_event(OP_MEASURE, 32'd100, 24'd0);     // elapsed clamps to the window
        offer_event(OP_MEASURE, 32'd20, 24'd0);      // negative elapsed, future stamps
        offer_event(OP_COUNT, 32'h7FFF_FFFF, 24'd12345);
        offer_event(OP_COUNT, 32'hFFFF_FFFF, 24'd0);
        offer_event(OP_MEASURE, 32'h8000_0000, 24'd0);
        offer_event(OP_STOP, 32'd60, 24'd0);
        offer_event(OP_MEASURE, 32'd60, 24'd0);
        offer_event(OP_START, 32'hFFFF_FFF0, 24'd0);
        offer_event(OP_COUNT, 32'hFFFF_FFF5, 24'd2000);
        offer_event(OP_STOP, 32'h0000_0010, 24'd0);  // elapsed wraps through zero
        offer_event(OP_COUNT, 32'h0000_0010, 24'hAA_AAAA);
        offer_event(OP_MEASURE, 32'h5555_5555, 24'h55_5555);

        while (events_sent < EVENT_GOAL) begin
            if ($urandom_range(0, 99) < 80)
                run_session();
            else
                run_noise($urandom_range(1, 8));
        end
        s_valid <= 1'b0;

        while (shadow.owed() != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (shadow.mismatches == 0)
            $display("tb_windowed_byte_rate_meter passed");
        else
            $display("tb_windowed_byte_rate_meter failed");
        $finish;
    end

endmodule
